// ----- design/pts_pkg.sv -----
// Package for the priority task scheduler: constants, codes and types.
package pts_pkg;

  localparam int MAX_TASKS_DEF = 8;
  localparam int NUM_SEMAPHORES_DEF = 4;
  localparam int PRIORITY_BITS_DEF = 4;

  localparam logic [1:0] ST_SUSPENDED = 2'd0;
  localparam logic [1:0] ST_READY = 2'd1;
  localparam logic [1:0] ST_RUNNING = 2'd2;
  localparam logic [1:0] ST_WAITING = 2'd3;

  localparam logic [3:0] ACT_START = 4'd0;
  localparam logic [3:0] ACT_TICK = 4'd1;
  localparam logic [3:0] ACT_ACTIVATE = 4'd2;
  localparam logic [3:0] ACT_TERMINATE = 4'd3;
  localparam logic [3:0] ACT_CHAIN = 4'd4;
  localparam logic [3:0] ACT_DELAY = 4'd5;
  localparam logic [3:0] ACT_YIELD = 4'd6;
  localparam logic [3:0] ACT_SEM_INIT = 4'd7;
  localparam logic [3:0] ACT_SEM_WAIT = 4'd8;
  localparam logic [3:0] ACT_SEM_SIGNAL = 4'd9;

  localparam logic [1:0] REG_TASK_COUNT = 2'd0;
  localparam logic [1:0] REG_AUTOSTART = 2'd1;
  localparam logic [1:0] REG_PRIORITY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE,
    S_SWEEP,
    S_SCAN,
    S_DONE
  } sched_state_t;

endpackage

// ----- design/pts_task_mem.sv -----
// Task table memory: state and delay count per task, registered read port.
module pts_task_mem import pts_pkg::*; #(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  localparam int TW = $clog2(MAX_TASKS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [TW-1:0] waddr,
  input  logic [1:0]    wstate,
  input  logic [31:0]   wdelay,
  input  logic [TW-1:0] raddr,
  output logic [1:0]    rstate,
  output logic [31:0]   rdelay
);
  logic [33:0] mem [MAX_TASKS];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= {wstate, wdelay};
    {rstate, rdelay} <= mem[raddr];
  end
endmodule

// ----- design/priority_task_scheduler.sv -----
// Top level of the priority task scheduler: control sequencer and semaphores.
// Actions that leave the table alone go straight to the done state; tick and a semaphore
// wake make one sweep of the table; actions that reschedule sweep, then scan.
// One action at a time: busy stays high until the done cycle ends. The receiver cannot stall.
// Reset (synchronous) clears the task table; busy stays high while it clears.
module priority_task_scheduler import pts_pkg::*; #(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  parameter int NUM_SEMAPHORES = NUM_SEMAPHORES_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [3:0]  action,
  input  logic [3:0]  task_id,
  input  logic [31:0] amount,
  input  logic [1:0]  sem_id,
  output logic        valid,
  output logic [2:0]  running_task,
  output logic        dispatched,
  output logic        status,
  output logic        blocked,
  output logic        expiry_seen
);
  localparam int TW = $clog2(MAX_TASKS);
  localparam int CW = TW + 1;
  localparam logic [CW-1:0] NT = CW'(MAX_TASKS);

  sched_state_t st, st_next;
  logic [3:0] task_count;
  logic [7:0] autostart_mask;
  logic [31:0] priority_table;

  logic [3:0] act;
  logic [3:0] tid;
  logic [TW-1:0] tid_w;
  logic [31:0] amt;
  logic [1:0] sid;
  logic [TW-1:0] cur;
  logic expiry_flag;
  logic clearing;
  logic [CW-1:0] idx;   // read pointer during the sweep
  logic rd_vld;
  logic [TW-1:0] ridx;  // entry whose data is on the read port
  logic is_task, resched, err, blk, disp;
  logic waker_vld;
  logic [TW-1:0] waker;
  logic found;
  logic [PRIORITY_BITS-1:0] best;
  logic [TW-1:0] pick;
  logic [31:0] pick_dly;
  logic [CW-1:0] n_act;

  logic [31:0] sem_count [NUM_SEMAPHORES];
  logic [NUM_SEMAPHORES-1:0] wt_vld;
  logic [TW-1:0] wt_task [NUM_SEMAPHORES];
  logic sem_ok;

  logic we;
  logic [TW-1:0] waddr, raddr;
  logic [1:0] wstate, rstate, nst;
  logic [31:0] wdelay, rdelay, ndelay;

  pts_task_mem #(.MAX_TASKS(MAX_TASKS)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wstate(wstate), .wdelay(wdelay),
    .raddr(raddr), .rstate(rstate), .rdelay(rdelay)
  );

  assign n_act = (32'(task_count) > 32'(MAX_TASKS)) ? NT : CW'(task_count);
  assign tid_w = TW'(tid);
  assign sem_ok = 32'(sem_id) < 32'(NUM_SEMAPHORES);
  assign busy = (st != S_IDLE) || clearing;

  function automatic logic [PRIORITY_BITS-1:0] prio(logic [31:0] tbl,
                                                    logic [TW-1:0] t);
    int sh;
    sh = int'(t) * PRIORITY_BITS;
    if (sh >= 32) return '0;
    return PRIORITY_BITS'(tbl >> sh);
  endfunction

  // Modify one task entry during the sweep.
  always_comb begin
    nst = rstate;
    ndelay = rdelay;
    case (act)
      ACT_START: nst = (32'(ridx) < 32'(task_count) && 32'(ridx) < 8
                        && autostart_mask[ridx[TW-1:0] & TW'(7)])
                       ? ST_READY
                       : ((CW'(ridx) < n_act) ? ST_SUSPENDED : rstate);
      ACT_TICK: if (rstate == ST_WAITING && rdelay != 0) begin
        ndelay = rdelay - 32'd1;
        if (ndelay == 0) nst = ST_READY;
      end
      ACT_ACTIVATE: if (ridx == tid_w || ridx == cur) nst = ST_READY;
      ACT_TERMINATE: if (ridx == cur) nst = ST_SUSPENDED;
      ACT_CHAIN: begin
        if (ridx == cur) nst = ST_SUSPENDED;
        else if (32'(tid) < 32'(MAX_TASKS) && ridx == tid_w) nst = ST_READY;
      end
      ACT_DELAY: if (ridx == cur) begin nst = ST_WAITING; ndelay = amt; end
      ACT_YIELD: if (ridx == cur) nst = ST_READY;
      ACT_SEM_WAIT: if (ridx == cur) nst = ST_WAITING;
      ACT_SEM_SIGNAL: if (waker_vld && ridx == waker) nst = ST_READY;
      default: ;
    endcase
  end

  always_comb begin
    st_next = st;
    case (st)
      S_IDLE: if (start && !clearing) st_next = is_task ? S_SWEEP : S_DONE;
      S_PRE: st_next = S_SWEEP;
      S_SWEEP: if (rd_vld && 32'(ridx) == MAX_TASKS - 1)
        st_next = resched ? S_SCAN : S_DONE;
      S_SCAN: if (rd_vld && 32'(ridx) == MAX_TASKS - 1) st_next = S_DONE;
      S_DONE: st_next = S_IDLE;
      default: st_next = S_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    we = 1'b0;
    waddr = ridx;
    wstate = nst;
    wdelay = ndelay;
    raddr = (st == S_IDLE || idx == NT) ? '0 : idx[TW-1:0];
    if (clearing) begin
      we = 1'b1;
      waddr = idx[TW-1:0];
      wstate = ST_SUSPENDED;
      wdelay = '0;
    end else if (st == S_SWEEP && rd_vld) begin
      we = 1'b1;
    end else if (st == S_DONE && found && resched) begin
      we = 1'b1;
      waddr = pick;
      wstate = ST_RUNNING;
      wdelay = pick_dly;
    end
  end

  // Marks the cycle after a dispatch, for the check on the current task.
  logic fix_pend;
  logic [TW-1:0] fix_addr;

  // An action walks the table unless it only touches a semaphore or changes nothing.
  always_comb begin
    is_task = 1'b0;
    case (action)
      ACT_START, ACT_TICK, ACT_TERMINATE, ACT_CHAIN, ACT_DELAY, ACT_YIELD: is_task = 1'b1;
      ACT_ACTIVATE: is_task = 32'(task_id) < 32'(MAX_TASKS);
      ACT_SEM_WAIT: is_task = sem_ok && (sem_count[sem_id] == '0);
      ACT_SEM_SIGNAL: is_task = sem_ok && wt_vld[sem_id];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      task_count <= 4'd8;
      autostart_mask <= 8'd1;
      priority_table <= '0;
      cur <= '0;
      expiry_flag <= 1'b0;
      clearing <= 1'b1;
      idx <= '0;
      rd_vld <= 1'b0;
      wt_vld <= '0;
      valid <= 1'b0;
      fix_pend <= 1'b0;
      for (int s = 0; s < NUM_SEMAPHORES; s++) sem_count[s] <= '0;
    end else begin
      valid <= (st == S_DONE);
      fix_pend <= (st == S_DONE) && found && resched;
      if (cfg_we) begin
        case (cfg_index)
          REG_TASK_COUNT: task_count <= cfg_data[3:0];
          REG_AUTOSTART: autostart_mask <= cfg_data[7:0];
          REG_PRIORITY: priority_table <= cfg_data;
          default: ;
        endcase
      end
      if (clearing) begin
        if (idx == NT - CW'(1)) begin clearing <= 1'b0; idx <= '0; end
        else idx <= idx + CW'(1);
      end
      st <= st_next;
      case (st)
        S_IDLE: if (start && !clearing) begin
          act <= action; tid <= task_id; amt <= amount; sid <= sem_id;
          err <= (action == ACT_ACTIVATE) && (32'(task_id) >= 32'(MAX_TASKS));
          blk <= (action == ACT_SEM_WAIT) && is_task;
          waker_vld <= (action == ACT_SEM_SIGNAL) && is_task;
          resched <= is_task && (action != ACT_TICK) && (action != ACT_SEM_SIGNAL);
          disp <= 1'b0; found <= 1'b0; best <= '0; pick <= '0;
          idx <= CW'(1); ridx <= '0; rd_vld <= 1'b1;
          case (action)
            ACT_YIELD: expiry_flag <= 1'b0;
            ACT_SEM_INIT: if (sem_ok) begin
              sem_count[sem_id] <= amount; wt_vld[sem_id] <= 1'b0;
            end
            ACT_SEM_WAIT: if (sem_ok) begin
              if (sem_count[sem_id] != 0) sem_count[sem_id] <= sem_count[sem_id] - 32'd1;
              else begin
                wt_vld[sem_id] <= 1'b1; wt_task[sem_id] <= cur;
              end
            end
            ACT_SEM_SIGNAL: if (sem_ok) begin
              if (wt_vld[sem_id]) begin
                wt_vld[sem_id] <= 1'b0; waker <= wt_task[sem_id];
              end else if (sem_count[sem_id] != '1)
                sem_count[sem_id] <= sem_count[sem_id] + 32'd1;
            end
            default: ;
          endcase
        end
        S_SWEEP, S_SCAN: begin
          if (st == S_SWEEP && rd_vld && act == ACT_TICK && rstate == ST_WAITING
              && rdelay == 32'd1) expiry_flag <= 1'b1;
          if (st == S_SWEEP && act == ACT_START && rd_vld && 32'(ridx) < 8
              && CW'(ridx) < n_act && autostart_mask[ridx[TW-1:0] & TW'(7)])
            cur <= ridx;
          if (st == S_SCAN && rd_vld && rstate == ST_READY && CW'(ridx) < n_act
              && prio(priority_table, ridx) >= best) begin
            best <= prio(priority_table, ridx); pick <= ridx; found <= 1'b1;
            pick_dly <= rdelay;
          end
          if (rd_vld && 32'(ridx) == MAX_TASKS - 1) begin
            idx <= CW'(1); ridx <= '0;
          end else begin
            ridx <= idx[TW-1:0]; idx <= idx + CW'(1);
          end
        end
        S_DONE: begin
          rd_vld <= 1'b0;
          if (found && resched) begin cur <= pick; disp <= 1'b1; end
          fix_addr <= pick;
        end
        default: ;
      endcase
    end
  end

  assign running_task = 3'(cur);
  assign dispatched = disp;
  assign status = err;
  assign blocked = blk;
  assign expiry_seen = expiry_flag;

  // fix_addr is kept for the assertion below on the running entry.
`ifndef NO_ASSERTIONS
  a_busy_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> busy) else $error("busy low while clearing");
  a_valid_once: assert property (@(posedge clk) disable iff (rst)
    valid |=> !valid) else $error("result strobe held two cycles");
  a_disp_cur: assert property (@(posedge clk) disable iff (rst)
    fix_pend |-> (cur == fix_addr)) else $error("current task not the pick");
  a_err_nodisp: assert property (@(posedge clk) disable iff (rst)
    (valid && status) |-> !dispatched) else $error("dispatch on error");
`endif
endmodule

// ----- tb/sv/tb_priority_task_scheduler.sv -----
// Testbench for the priority task scheduler: directed and random actions checked against a model.
module tb_priority_task_scheduler import pts_pkg::*; ();

  typedef struct packed {
    logic [2:0] running_task;
    logic       dispatched;
    logic       status;
    logic       blocked;
    logic       expiry_seen;
  } sched_result_t;

  class sched_scoreboard;
    logic [3:0]  task_count;
    logic [7:0]  autostart_mask;
    logic [31:0] priority_table;
    logic [1:0]  task_state [8];
    logic [31:0] delay_count [8];
    logic [2:0]  current_task;
    logic        expiry_flag;
    logic [31:0] sem_count [4];
    logic        waiter_valid [4];
    logic [2:0]  waiter_task [4];
    sched_result_t pending_results [$];
    int errors;
    int checked;

    function void clear();
      task_count = 4'd8;
      autostart_mask = 8'd1;
      priority_table = 32'd0;
      for (int i = 0; i < 8; i++) begin
        task_state[i] = ST_SUSPENDED;
        delay_count[i] = 32'd0;
      end
      current_task = 3'd0;
      expiry_flag = 1'b0;
      for (int i = 0; i < 4; i++) begin
        sem_count[i] = 32'd0;
        waiter_valid[i] = 1'b0;
        waiter_task[i] = 3'd0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_TASK_COUNT: task_count = data[3:0];
        REG_AUTOSTART: autostart_mask = data[7:0];
        REG_PRIORITY: priority_table = data;
        default: ;
      endcase
    endfunction

    // Highest priority ready task wins; ties go to the higher index.
    function logic pick_task();
      int n;
      int pick;
      logic [3:0] best;
      logic found;
      n = task_count > 8 ? 8 : task_count;
      best = 4'd0;
      pick = 0;
      found = 1'b0;
      for (int t = 0; t < n; t++) begin
        if (task_state[t] == ST_READY && priority_table[t*4 +: 4] >= best) begin
          best = priority_table[t*4 +: 4];
          pick = t;
          found = 1'b1;
        end
      end
      if (found) begin
        current_task = pick[2:0];
        task_state[pick] = ST_RUNNING;
      end
      return found;
    endfunction

    function void note_action(logic [3:0] act, logic [3:0] tid, logic [31:0] amt,
                              logic [1:0] sid);
      sched_result_t r;
      int n;
      r = '0;
      case (act)
        ACT_START: begin
          n = task_count > 8 ? 8 : task_count;
          for (int i = 0; i < n; i++) begin
            if (autostart_mask[i]) begin
              current_task = i[2:0];
              task_state[i] = ST_READY;
            end else begin
              task_state[i] = ST_SUSPENDED;
            end
          end
          r.dispatched = pick_task();
        end
        ACT_TICK: begin
          for (int i = 0; i < 8; i++) begin
            if (task_state[i] == ST_WAITING && delay_count[i] != 0) begin
              delay_count[i] = delay_count[i] - 1;
              if (delay_count[i] == 0) begin
                task_state[i] = ST_READY;
                expiry_flag = 1'b1;
              end
            end
          end
        end
        ACT_ACTIVATE: begin
          if (tid >= 8) begin
            r.status = 1'b1;
          end else begin
            task_state[tid[2:0]] = ST_READY;
            task_state[current_task] = ST_READY;
            r.dispatched = pick_task();
          end
        end
        ACT_TERMINATE: begin
          task_state[current_task] = ST_SUSPENDED;
          r.dispatched = pick_task();
        end
        ACT_CHAIN: begin
          if (tid < 8) task_state[tid[2:0]] = ST_READY;
          task_state[current_task] = ST_SUSPENDED;
          r.dispatched = pick_task();
        end
        ACT_DELAY: begin
          delay_count[current_task] = amt;
          task_state[current_task] = ST_WAITING;
          r.dispatched = pick_task();
        end
        ACT_YIELD: begin
          expiry_flag = 1'b0;
          task_state[current_task] = ST_READY;
          r.dispatched = pick_task();
        end
        ACT_SEM_INIT: begin
          sem_count[sid] = amt;
          waiter_valid[sid] = 1'b0;
          waiter_task[sid] = 3'd0;
        end
        ACT_SEM_WAIT: begin
          if (sem_count[sid] != 0) begin
            sem_count[sid] = sem_count[sid] - 1;
          end else begin
            waiter_valid[sid] = 1'b1;
            waiter_task[sid] = current_task;
            task_state[current_task] = ST_WAITING;
            r.blocked = 1'b1;
            r.dispatched = pick_task();
          end
        end
        ACT_SEM_SIGNAL: begin
          if (waiter_valid[sid]) begin
            task_state[waiter_task[sid]] = ST_READY;
            waiter_valid[sid] = 1'b0;
            waiter_task[sid] = 3'd0;
          end else if (sem_count[sid] != 32'hFFFF_FFFF) begin
            sem_count[sid] = sem_count[sid] + 1;
          end
        end
        default: ;
      endcase
      r.running_task = current_task;
      r.expiry_seen = expiry_flag;
      pending_results.push_back(r);
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t exp_r;
      checked++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.running_task !== exp_r.running_task) begin
        $display("%0t: running_task expected %0d actual %0d", $time,
                 exp_r.running_task, got.running_task);
        errors++;
      end
      if (got.dispatched !== exp_r.dispatched) begin
        $display("%0t: dispatched expected %0b actual %0b", $time,
                 exp_r.dispatched, got.dispatched);
        errors++;
      end
      if (got.status !== exp_r.status) begin
        $display("%0t: status expected %0b actual %0b", $time, exp_r.status, got.status);
        errors++;
      end
      if (got.blocked !== exp_r.blocked) begin
        $display("%0t: blocked expected %0b actual %0b", $time, exp_r.blocked, got.blocked);
        errors++;
      end
      if (got.expiry_seen !== exp_r.expiry_seen) begin
        $display("%0t: expiry_seen expected %0b actual %0b", $time,
                 exp_r.expiry_seen, got.expiry_seen);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic [3:0]  action = '0;
  logic [3:0]  task_id = '0;
  logic [31:0] amount = '0;
  logic [1:0]  sem_id = '0;
  logic        valid;
  logic [2:0]  running_task;
  logic        dispatched;
  logic        status;
  logic        blocked;
  logic        expiry_seen;

  sched_scoreboard sb;
  int sent;

  priority_task_scheduler dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && valid) sb.check_result({running_task, dispatched, status, blocked, expiry_seen});
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  // Waits for all outstanding beats to be checked.
  task automatic drain();
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic send(logic [3:0] act, logic [3:0] tid, logic [31:0] amt, logic [1:0] sid,
                      bit may_idle);
    if (may_idle) begin
      while ($urandom_range(99) < 19) @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    task_id <= tid;
    amount <= amt;
    sem_id <= sid;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_action(act, tid, amt, sid);
    sent++;
    start <= 1'b0;
    // The block is busy for at least this cycle after an accept.
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_amount();
    case ($urandom_range(3))
      0: return $urandom_range(3);
      1: return $urandom_range(12);
      2: return 32'hFFFF_FFFF - $urandom_range(2);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int count, bit calm);
    logic [3:0] act;
    for (int i = 0; i < count; i++) begin
      // Mostly scheduling actions; a few unused codes as noise.
      if ($urandom_range(29) == 0) act = 4'(10 + $urandom_range(5));
      else act = 4'($urandom_range(9));
      send(act, 4'(($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(7)),
           rand_amount(), 2'($urandom_range(3)), !calm);
    end
  endtask

  initial begin
    #2000000;
    $display("tb_priority_task_scheduler NOT OK");
    $finish;
  end

  initial begin
    sb = new();
    sb.clear();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    // Directed: defaults, then every action and the corner cases.
    send(ACT_START, 4'd0, 32'd0, 2'd0, 0);
    drain();
    write_reg(REG_PRIORITY, 32'h1234_5678);
    write_reg(REG_AUTOSTART, 32'hFF);
    write_reg(REG_TASK_COUNT, 32'd8);
    send(ACT_START, 4'd0, 32'd0, 2'd0, 0);
    send(ACT_ACTIVATE, 4'd15, 32'd0, 2'd0, 0);
    send(ACT_ACTIVATE, 4'd8, 32'd0, 2'd0, 0);
    send(ACT_ACTIVATE, 4'd7, 32'd0, 2'd0, 0);
    send(ACT_DELAY, 4'd0, 32'd2, 2'd0, 0);
    send(ACT_DELAY, 4'd0, 32'd0, 2'd0, 0);
    send(ACT_TICK, 4'd0, 32'd0, 2'd0, 0);
    send(ACT_TICK, 4'd0, 32'd0, 2'd0, 0);
    send(ACT_YIELD, 4'd0, 32'd0, 2'd0, 0);
    send(ACT_CHAIN, 4'd12, 32'd0, 2'd0, 0);
    send(ACT_CHAIN, {1'b0, running_task}, 32'd0, 2'd0, 0);
    send(ACT_SEM_INIT, 4'd0, 32'hFFFF_FFFF, 2'd3, 0);
    send(ACT_SEM_SIGNAL, 4'd0, 32'd0, 2'd3, 0);
    send(ACT_SEM_WAIT, 4'd0, 32'd0, 2'd3, 0);
    send(ACT_SEM_INIT, 4'd0, 32'd0, 2'd1, 0);
    send(ACT_SEM_WAIT, 4'd0, 32'd0, 2'd1, 0);
    send(ACT_SEM_SIGNAL, 4'd0, 32'd0, 2'd1, 0);
    send(ACT_TERMINATE, 4'd0, 32'd0, 2'd0, 0);
    send(4'd15, 4'd0, 32'd0, 2'd0, 0);
    send(4'd10, 4'd0, 32'd0, 2'd0, 0);
    drain();
    write_reg(REG_TASK_COUNT, 32'd0);
    send(ACT_START, 4'd0, 32'd0, 2'd0, 0);
    send(ACT_YIELD, 4'd0, 32'd0, 2'd0, 0);
    drain();

    // Random phases over several register settings, extremes included.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: write_reg(REG_TASK_COUNT, 32'd15);
        1: write_reg(REG_TASK_COUNT, 32'd1);
        default: write_reg(REG_TASK_COUNT, $urandom_range(2, 15));
      endcase
      write_reg(REG_AUTOSTART, ph == 3 ? 32'd0 : (ph == 4 ? 32'hFF : $urandom));
      write_reg(REG_PRIORITY, ph == 5 ? 32'd0 : (ph == 6 ? 32'hFFFF_FFFF : $urandom));
      send(ACT_START, 4'd0, 32'd0, 2'd0, 0);
      random_phase(97, ph == 2);
      drain();
    end

    $display("Sent %0d scheduler actions over ten register settings; %0d result beats checked.",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("tb_priority_task_scheduler OK");
    end else begin
      $display("tb_priority_task_scheduler NOT OK");
    end
    $finish;
  end
endmodule

// ----- files.f -----
design/pts_pkg.sv
design/pts_task_mem.sv
design/priority_task_scheduler.sv
tb/sv/tb_priority_task_scheduler.sv
